[rtl/core/multi_slot_tick_timer_table_defines.svh]
// Assertion macros used by the timer table checker.
`ifndef MULTI_SLOT_TICK_TIMER_TABLE_DEFINES_SVH
`define MULTI_SLOT_TICK_TIMER_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define MSTT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define MSTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/mstt_pkg.sv]
// Shared codes and controller/datapath interface types for the timer table.
package mstt_pkg;

    // Command codes of an input word
    localparam logic [1:0] CMD_REGISTER   = 2'd0;
    localparam logic [1:0] CMD_UNREGISTER = 2'd1;
    localparam logic [1:0] CMD_TICK       = 2'd2;
    // Not a command; drop the word with no result
    localparam logic [1:0] CMD_IGNORED    = 2'd3;

    // Kind codes of a result word
    localparam logic [1:0] KIND_REG_REPLY   = 2'd0;
    localparam logic [1:0] KIND_UNREG_REPLY = 2'd1;
    localparam logic [1:0] KIND_FIRED       = 2'd2;
    localparam logic [1:0] KIND_NO_FIRE     = 2'd3;

    // Fire results emitted per tick at most
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned FIRE_CNT_W  = $clog2(MAX_RESULTS + 1);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // latch the input word
        logic idx_clear; // rewind the slot pointer
        logic scan;      // advance the pointer while searching a free slot
        logic claim;     // take the slot under the pointer, reply ok
        logic reg_fail;  // reply table full
        logic unreg;     // free the selected slot, reply
        logic walk_rd;   // read the slot under the pointer, advance
        logic flush;     // emit the closing result of a tick
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic slot_free; // slot under the pointer is not in use
        logic idx_end;   // pointer is at the highest slot
    } dp_stat_t;

endpackage

[rtl/core/mstt_ctrl.sv]
// Sequencer for the timer table: command decode, free-slot search and tick walk.
module mstt_ctrl
    import mstt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic [1:0] command,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REG,
        S_UNREG,
        S_WALK,
        S_LAST,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load      = 1'b1;
                    cmd.idx_clear = 1'b1;
                    unique case (command)
                        CMD_REGISTER:   state_next = S_REG;
                        CMD_UNREGISTER: state_next = S_UNREG;
                        CMD_TICK:       state_next = S_WALK;
                        default:        state_next = S_IDLE;
                    endcase
                end
            end
            S_REG:
            begin
                priority if (stat.slot_free)
                begin
                    cmd.claim  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.idx_end)
                begin
                    cmd.reg_fail = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            S_UNREG:
            begin
                cmd.unreg  = 1'b1;
                state_next = S_IDLE;
            end
            S_WALK:
            begin
                cmd.walk_rd = 1'b1;
                if (stat.idx_end)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

[rtl/core/mstt_datapath.sv]
// Slot storage, slot pointer, tick arithmetic and result register of the timer table.
module mstt_datapath
    import mstt_pkg::*;
#(
    parameter int unsigned NUM_SLOTS    = 16,
    parameter int unsigned COUNT_WIDTH  = 16,
    parameter int unsigned HANDLE_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic [15:0] period_ticks,
    input  logic        periodic,
    input  logic [15:0] handle,
    input  logic [5:0]  slot_select,
    output logic        strobe,
    output logic [1:0]  kind,
    output logic        ok,
    output logic [3:0]  slot_index,
    output logic [15:0] fired_handle,
    output logic        last
);

    localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Latched input word
    logic [COUNT_WIDTH-1:0]  period_reg;
    logic                    periodic_reg;
    logic [HANDLE_WIDTH-1:0] handle_reg;
    logic [5:0]              sel_reg;

    // Slot state
    logic [NUM_SLOTS-1:0]    valid_reg;
    logic [COUNT_WIDTH-1:0]  cnt_mem    [NUM_SLOTS];
    logic [COUNT_WIDTH-1:0]  period_mem [NUM_SLOTS];
    logic [HANDLE_WIDTH-1:0] handle_mem [NUM_SLOTS];
    logic                    per_mem    [NUM_SLOTS];

    // Walk pointer and read stage
    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W-1:0]        proc_idx_reg;
    logic                    proc_vld_reg;
    logic [COUNT_WIDTH-1:0]  cnt_rd_reg;
    logic [COUNT_WIDTH-1:0]  period_rd_reg;
    logic [HANDLE_WIDTH-1:0] handle_rd_reg;
    logic                    per_rd_reg;

    // Held fire result and fire count of the current tick
    logic                    hold_vld_reg;
    logic [IDX_W-1:0]        hold_idx_reg;
    logic [HANDLE_WIDTH-1:0] hold_handle_reg;
    logic [FIRE_CNT_W-1:0]   fire_cnt_reg;

    // Result register
    logic        strobe_reg;
    logic [1:0]  kind_reg;
    logic        ok_reg;
    logic [3:0]  slot_reg;
    logic [15:0] fhandle_reg;
    logic        last_reg;

    logic                   sel_in_range;
    logic                   sel_valid;
    logic                   active;
    logic [COUNT_WIDTH-1:0] cnt_dec;
    logic                   fire;
    logic                   fire_emit;
    logic                   cnt_we;
    logic [COUNT_WIDTH-1:0] cnt_wdata;
    logic [IDX_W-1:0]       cnt_waddr;

    assign stat.slot_free = ~valid_reg[idx_reg];
    assign stat.idx_end   = (idx_reg == IDX_W'(NUM_SLOTS - 1));

    assign sel_in_range = ({1'b0, sel_reg} < 7'(NUM_SLOTS));
    assign sel_valid    = sel_in_range && valid_reg[sel_reg[IDX_W-1:0]];

    // Tick step on the slot read in the previous cycle
    assign active    = proc_vld_reg && valid_reg[proc_idx_reg] && (cnt_rd_reg != '0);
    assign cnt_dec   = cnt_rd_reg - COUNT_WIDTH'(1);
    assign fire      = active && (cnt_dec == '0);
    assign fire_emit = fire && (fire_cnt_reg < FIRE_CNT_W'(MAX_RESULTS));

    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_wdata = cnt_dec;
        cnt_waddr = proc_idx_reg;
        priority if (cmd.claim)
        begin
            cnt_we    = 1'b1;
            cnt_wdata = period_reg;
            cnt_waddr = idx_reg;
        end
        else if (active)
        begin
            cnt_we    = !fire || per_rd_reg;
            cnt_wdata = fire ? period_rd_reg : cnt_dec;
        end
        else
        begin
            cnt_we = 1'b0;
        end
    end

    // Slot memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cmd.claim)
        begin
            period_mem[idx_reg] <= period_reg;
            handle_mem[idx_reg] <= handle_reg;
            per_mem[idx_reg]    <= periodic_reg;
        end
        if (cmd.walk_rd)
        begin
            cnt_rd_reg    <= cnt_mem[idx_reg];
            period_rd_reg <= period_mem[idx_reg];
            handle_rd_reg <= handle_mem[idx_reg];
            per_rd_reg    <= per_mem[idx_reg];
        end
    end

    // Input latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            period_reg   <= COUNT_WIDTH'(period_ticks);
            periodic_reg <= periodic;
            handle_reg   <= HANDLE_WIDTH'(handle);
            sel_reg      <= slot_select;
        end
    end

    // Control state: valid bits, pointer, read stage, fire bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            idx_reg      <= '0;
            proc_idx_reg <= '0;
            proc_vld_reg <= 1'b0;
            hold_vld_reg <= 1'b0;
            fire_cnt_reg <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            proc_vld_reg <= cmd.walk_rd;
            strobe_reg   <= cmd.claim || cmd.reg_fail || cmd.unreg || cmd.flush
                            || (fire_emit && hold_vld_reg);
            if (cmd.walk_rd)
            begin
                proc_idx_reg <= idx_reg;
            end
            priority if (cmd.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if ((cmd.scan || cmd.walk_rd) && !stat.idx_end)
            begin
                idx_reg <= IDX_W'(idx_reg + 1'b1);
            end
            else
            begin
                idx_reg <= idx_reg;
            end
            if (cmd.load)
            begin
                hold_vld_reg <= 1'b0;
                fire_cnt_reg <= '0;
            end
            else if (fire_emit)
            begin
                hold_vld_reg <= 1'b1;
                fire_cnt_reg <= FIRE_CNT_W'(fire_cnt_reg + 1'b1);
            end
            if (cmd.claim)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
            if (cmd.unreg && sel_valid)
            begin
                valid_reg[sel_reg[IDX_W-1:0]] <= 1'b0;
            end
            if (fire && !per_rd_reg)
            begin
                valid_reg[proc_idx_reg] <= 1'b0;
            end
        end
    end

    // Held fire payload
    always_ff @(posedge clk)
    begin
        if (fire_emit)
        begin
            hold_idx_reg    <= proc_idx_reg;
            hold_handle_reg <= handle_rd_reg;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        priority if (cmd.claim)
        begin
            kind_reg    <= KIND_REG_REPLY;
            ok_reg      <= 1'b1;
            slot_reg    <= 4'(idx_reg);
            fhandle_reg <= '0;
            last_reg    <= 1'b1;
        end
        else if (cmd.reg_fail)
        begin
            kind_reg    <= KIND_REG_REPLY;
            ok_reg      <= 1'b0;
            slot_reg    <= '0;
            fhandle_reg <= '0;
            last_reg    <= 1'b1;
        end
        else if (cmd.unreg)
        begin
            kind_reg    <= KIND_UNREG_REPLY;
            ok_reg      <= sel_valid;
            slot_reg    <= sel_reg[3:0];
            fhandle_reg <= '0;
            last_reg    <= 1'b1;
        end
        else if (cmd.flush && !hold_vld_reg)
        begin
            kind_reg    <= KIND_NO_FIRE;
            ok_reg      <= 1'b0;
            slot_reg    <= '0;
            fhandle_reg <= '0;
            last_reg    <= 1'b1;
        end
        else if (cmd.flush || (fire_emit && hold_vld_reg))
        begin
            kind_reg    <= KIND_FIRED;
            ok_reg      <= 1'b0;
            slot_reg    <= 4'(hold_idx_reg);
            fhandle_reg <= 16'(hold_handle_reg);
            last_reg    <= cmd.flush;
        end
        else
        begin
            kind_reg <= kind_reg;
        end
    end

    assign strobe       = strobe_reg;
    assign kind         = kind_reg;
    assign ok           = ok_reg;
    assign slot_index   = slot_reg;
    assign fired_handle = fhandle_reg;
    assign last         = last_reg;

endmodule

[rtl/core/multi_slot_tick_timer_table.sv]
// Top level of the multi-slot tick timer table.
//
// Usage: drive command and its fields with start high; the word is taken on a
// rising edge where start is high and busy is low. Commands: register a timer
// (claims the lowest free slot), unregister a slot, or one tick. Code 3 is
// dropped with no result.
// Results appear one word per cycle, marked by strobe for exactly one cycle;
// last flags the final word of a command. The receiver cannot stall, so take
// every strobe.
// Unregister replies from the UNREG state. Register scans the valid bits one
// slot per cycle and replies at the first free slot or at the highest slot.
// A tick walks the slot memory one slot per cycle through a registered read
// port and ends through the LAST and FLUSH states; fire words come out
// during the walk, the closing word at its end. Busy drops on the edge that
// presents the closing word; a command is taken only when the last is done.
// Reset clears all valid bits and the sequencer; slot periods, counters and
// handles are written on register and need no clearing.
module multi_slot_tick_timer_table
    import mstt_pkg::*;
#(
    parameter int unsigned NUM_SLOTS    = 16,
    parameter int unsigned COUNT_WIDTH  = 16,
    parameter int unsigned HANDLE_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [15:0] period_ticks,
    input  logic        periodic,
    input  logic [15:0] handle,
    input  logic [5:0]  slot_select,
    output logic        strobe,
    output logic [1:0]  kind,
    output logic        ok,
    output logic [3:0]  slot_index,
    output logic [15:0] fired_handle,
    output logic        last
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // Sequencer: decode the word, run the free-slot search or the tick walk
    mstt_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (dp_stat),
        .cmd     (dp_cmd),
        .busy    (busy)
    );

    // Slot storage and result register
    mstt_datapath #(
        .NUM_SLOTS    (NUM_SLOTS),
        .COUNT_WIDTH  (COUNT_WIDTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .stat         (dp_stat),
        .period_ticks (period_ticks),
        .periodic     (periodic),
        .handle       (handle),
        .slot_select  (slot_select),
        .strobe       (strobe),
        .kind         (kind),
        .ok           (ok),
        .slot_index   (slot_index),
        .fired_handle (fired_handle),
        .last         (last)
    );

endmodule

[rtl/core/mstt_checker.sv]
// Port-level checker for the timer table and its bind to the top level.
`include "multi_slot_tick_timer_table_defines.svh"

module mstt_checker
    import mstt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  command,
    input logic        strobe,
    input logic [1:0]  kind,
    input logic        ok,
    input logic        last
);

    logic take_word;
    logic reply_word;
    logic tick_word;

    assign take_word  = start && !busy && (command != CMD_IGNORED);
    assign reply_word = strobe && (kind != KIND_FIRED);
    assign tick_word  = strobe && (kind == KIND_FIRED || kind == KIND_NO_FIRE);

    `MSTT_ASSERT_NEXT(a_accept_busy, take_word, busy, "accepted command did not raise busy")
    `MSTT_ASSERT_NEXT(a_quiet_after_last, strobe && last, !strobe, "word after closing word")
    `MSTT_ASSERT_NOW(a_reply_is_last, reply_word, last, "reply word without last")
    `MSTT_ASSERT_NOW(a_tick_not_ok, tick_word, !ok, "tick word with ok set")

endmodule

bind multi_slot_tick_timer_table mstt_checker u_mstt_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .command (command),
    .strobe  (strobe),
    .kind    (kind),
    .ok      (ok),
    .last    (last)
);
